### src/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

	localparam logic [2:0] FUNC_INSERT     = 3'd0;
	localparam logic [2:0] FUNC_POP        = 3'd1;
	localparam logic [2:0] FUNC_LIST_ALL   = 3'd2;
	localparam logic [2:0] FUNC_LIST_GPA   = 3'd3;
	localparam logic [2:0] FUNC_LIST_GRADE = 3'd4;
	localparam logic [2:0] FUNC_CLEAR      = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] tag;
		logic        blank;
		logic [7:0]  grade;
		logic [8:0]  gpa;
		logic [7:0]  attempts;
	} rec_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_ROTATE,
		OP_CLEAR
	} ring_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		ring_op_t   op;
		logic [2:0] func;
		rec_t       new_rec;
	} cell_ctl_t;

	// what a cell hands to its neighbours
	typedef struct packed {
		rec_t rec;
		logic occ;
	} cell_link_t;

endpackage

### src/stable_priority_queue_with_filters.sv
`timescale 1ns / 1ps
// Sorted record queue, largest attempts key at the head, equal keys in arrival
// order. Input channel (in_valid/in_stall) carries one command per transfer;
// output channel (out_valid/out_stall) carries results, last marks the final
// result of a command.
// Insert, pop, clear and unknown commands give a single result that is
// registered and appears the cycle after the input transfer, so such commands
// can follow one per cycle while their results drain and none stalls. Insert
// shifts the tail of the cell chain by one in that cycle, pop shifts the whole chain.
// A listing with matches rotates the record ring through all DEPTH cells,
// one cell per cycle while no result is stalled, and emits the matching records
// from cell 0 as they pass; the matches are captured in a mask at the transfer,
// the rotation begins once the state register enters the listing state, and
// the next command is taken after the ring has come all the way round.
// A listing without matches gives a single result with status empty.
// A new command is taken when the output register is empty or its result
// transfers in the same cycle; a stalled result holds in_stall high and stops
// the ring, and in_stall stays high during a listing.
// Reset empties the queue; record contents are not cleared.
module stable_priority_queue_with_filters #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] record_tag,
	input  logic        record_blank,
	input  logic [7:0]  grade,
	input  logic [8:0]  gpa,
	input  logic [7:0]  attempts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_tag,
	output logic        out_blank,
	output logic [7:0]  out_grade,
	output logic [8:0]  out_gpa,
	output logic [7:0]  out_attempts,
	output logic        last
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	spq_pkg::state_t     state_q;
	spq_pkg::state_t     state_d;
	spq_pkg::cell_ctl_t  ctl;
	spq_pkg::ring_op_t   op_d;
	spq_pkg::cell_link_t link_w [DEPTH];
	spq_pkg::cell_link_t wrap_link;
	logic [DEPTH-1:0]    ge_w;
	logic [DEPTH-1:0]    hit_w;
	logic [DEPTH-1:0]    occ_w;
	logic [DEPTH-1:0]    mask_q;
	logic [DEPTH-1:0]    mask_d;
	logic [SW-1:0]       step_q;
	logic [SW-1:0]       step_d;

	logic                slot_free;
	logic                accept;
	logic                full;
	logic                empty;
	logic                is_list;

	logic                out_valid_q;
	logic                load;
	logic [1:0]          status_d;
	spq_pkg::rec_t       rec_d;
	logic                last_d;
	logic [1:0]          status_q;
	spq_pkg::rec_t       rec_q;
	logic                last_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == spq_pkg::ST_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;
	assign full      = occ_w[DEPTH-1];
	assign empty     = !occ_w[0];
	assign is_list   = (func == spq_pkg::FUNC_LIST_ALL) || (func == spq_pkg::FUNC_LIST_GPA)
		|| (func == spq_pkg::FUNC_LIST_GRADE);

	assign ctl.op               = op_d;
	assign ctl.func             = func;
	assign ctl.new_rec.tag      = record_tag;
	assign ctl.new_rec.blank    = record_blank;
	assign ctl.new_rec.grade    = grade;
	assign ctl.new_rec.gpa      = gpa;
	assign ctl.new_rec.attempts = attempts;

	always_comb begin
		op_d = spq_pkg::OP_HOLD;
		if (accept) begin
			case (func)
				spq_pkg::FUNC_INSERT: op_d = full ? spq_pkg::OP_HOLD : spq_pkg::OP_INSERT;
				spq_pkg::FUNC_POP:    op_d = empty ? spq_pkg::OP_HOLD : spq_pkg::OP_POP;
				spq_pkg::FUNC_CLEAR:  op_d = spq_pkg::OP_CLEAR;
				default:              op_d = spq_pkg::OP_HOLD;
			endcase
		end else if (state_q == spq_pkg::ST_LIST && slot_free) begin
			op_d = spq_pkg::OP_ROTATE;
		end
	end

	// the tail refills from the head when rotating, and empties on pop
	assign wrap_link.rec = link_w[0].rec;
	assign wrap_link.occ = (op_d == spq_pkg::OP_ROTATE) && link_w[0].occ;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::cell_link_t left_l;
		spq_pkg::cell_link_t right_l;
		logic                left_ge_l;

		if (i == 0) begin : g_first
			assign left_l    = '0;
			assign left_ge_l = 1'b1;
		end else begin : g_mid
			assign left_l    = link_w[i-1];
			assign left_ge_l = ge_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_l = wrap_link;
		end else begin : g_inner
			assign right_l = link_w[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left_in  (left_l),
			.left_ge  (left_ge_l),
			.right_in (right_l),
			.cur      (link_w[i]),
			.ge       (ge_w[i]),
			.hit      (hit_w[i])
		);

		assign occ_w[i] = link_w[i].occ;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept && is_list && (|hit_w)) begin
					state_d = spq_pkg::ST_LIST;
				end
			end
			spq_pkg::ST_LIST: begin
				if (slot_free && step_q == SW'(DEPTH - 1)) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			default: state_d = spq_pkg::ST_IDLE;
		endcase
	end

	// result and scan control
	always_comb begin
		load     = 1'b0;
		status_d = spq_pkg::STAT_OK;
		rec_d    = '0;
		last_d   = 1'b1;
		mask_d   = mask_q;
		step_d   = step_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				step_d = '0;
				if (accept) begin
					load = 1'b1;
					case (func)
						spq_pkg::FUNC_INSERT: begin
							status_d = full ? spq_pkg::STAT_FULL : spq_pkg::STAT_OK;
						end
						spq_pkg::FUNC_POP: begin
							if (empty) begin
								status_d = spq_pkg::STAT_EMPTY;
							end else begin
								rec_d = link_w[0].rec;
							end
						end
						spq_pkg::FUNC_LIST_ALL, spq_pkg::FUNC_LIST_GPA,
						spq_pkg::FUNC_LIST_GRADE: begin
							mask_d = hit_w;
							if (|hit_w) begin
								load = 1'b0;
							end else begin
								status_d = spq_pkg::STAT_EMPTY;
							end
						end
						spq_pkg::FUNC_CLEAR: begin
							status_d = spq_pkg::STAT_OK;
						end
						default: begin
							status_d = spq_pkg::STAT_EMPTY;
						end
					endcase
				end
			end
			spq_pkg::ST_LIST: begin
				if (slot_free) begin
					load   = mask_q[0];
					rec_d  = link_w[0].rec;
					last_d = (mask_q >> 1) == '0;
					mask_d = mask_q >> 1;
					step_d = step_q + 1'b1;
				end
			end
			default: begin
				step_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			mask_q      <= '0;
			step_q      <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load || (out_valid_q && out_stall);
			mask_q      <= mask_d;
			step_q      <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_d;
			rec_q    <= rec_d;
			last_q   <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = rec_q.tag;
	assign out_blank    = rec_q.blank;
	assign out_grade    = rec_q.grade;
	assign out_gpa      = rec_q.gpa;
	assign out_attempts = rec_q.attempts;
	assign last         = last_q;

	// occupied cells form one run from the head whenever the ring is at rest
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::ST_IDLE |-> ((occ_w + 1'b1) & occ_w) == '0)
		else $error("occupancy not contiguous");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == spq_pkg::FUNC_INSERT && !full
		|=> $countones(occ_w) == $past($countones(occ_w)) + 1)
		else $error("insert did not add one entry");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == spq_pkg::FUNC_POP && empty
		|=> out_valid && status == spq_pkg::STAT_EMPTY && last)
		else $error("pop of empty queue not reported");

	a_ring_restored: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::ST_LIST && ctl.op == spq_pkg::OP_ROTATE
		|=> $countones(occ_w) == $past($countones(occ_w)))
		else $error("rotation changed entry count");

endmodule

### src/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctl_t  ctl,
	input  spq_pkg::cell_link_t left_in,
	input  logic               left_ge,
	input  spq_pkg::cell_link_t right_in,
	output spq_pkg::cell_link_t cur,
	output logic               ge,
	output logic               hit
);

	spq_pkg::rec_t rec_q;
	spq_pkg::rec_t rec_d;
	logic          occ_q;
	logic          occ_d;

	// entry holds its place when its key is at or above the new one
	assign ge = occ_q && (rec_q.attempts >= ctl.new_rec.attempts);

	always_comb begin
		rec_d = rec_q;
		occ_d = occ_q;
		case (ctl.op)
			spq_pkg::OP_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						rec_d = ctl.new_rec;
						occ_d = 1'b1;
					end else begin
						rec_d = left_in.rec;
						occ_d = left_in.occ;
					end
				end
			end
			spq_pkg::OP_POP, spq_pkg::OP_ROTATE: begin
				rec_d = right_in.rec;
				occ_d = right_in.occ;
			end
			spq_pkg::OP_CLEAR: begin
				occ_d = 1'b0;
			end
			default: begin
				rec_d = rec_q;
				occ_d = occ_q;
			end
		endcase
	end

	always_comb begin
		case (ctl.func)
			spq_pkg::FUNC_LIST_ALL:   hit = 1'b1;
			spq_pkg::FUNC_LIST_GPA:   hit = rec_q.gpa >= ctl.new_rec.gpa;
			spq_pkg::FUNC_LIST_GRADE: hit = rec_q.grade <= ctl.new_rec.grade;
			default:                  hit = 1'b0;
		endcase
		hit = hit && occ_q && !rec_q.blank;
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	assign cur.rec = rec_q;
	assign cur.occ = occ_q;

endmodule
